// ===== rtl/core/mfd_pkg.sv =====
// Shared types, codes and constant tables for the message frame deframer.
`default_nettype none

package mfd_pkg;

    // Parser position within a frame, one-hot.
    typedef enum logic [4:0] {
        PH_MAGIC   = 5'b00001,
        PH_LENGTH  = 5'b00010,
        PH_PROTO   = 5'b00100,
        PH_STRING  = 5'b01000,
        PH_CONTENT = 5'b10000
    } t_phase;

    typedef enum logic [2:0] {
        ERR_NONE     = 3'd0,
        ERR_MAGIC    = 3'd1,
        ERR_PROTOCOL = 3'd2,
        ERR_OVERRUN  = 3'd3,
        ERR_MISSING  = 3'd4,
        ERR_SHORT    = 3'd5
    } t_err;

    typedef logic signed [31:0] t_seq;

    // Field codes reported with each beat.
    localparam logic [3:0] FIELD_MAGIC   = 4'd0;
    localparam logic [3:0] FIELD_LENGTH  = 4'd1;
    localparam logic [3:0] FIELD_PROTO   = 4'd2;
    localparam logic [3:0] FIELD_STR0    = 4'd3;
    localparam logic [3:0] FIELD_CONTENT = 4'd11;

    // Positions of the string fields that the parser looks into.
    localparam logic [2:0] STR_DEST    = 3'd0;
    localparam logic [2:0] STR_SUBJECT = 3'd2;
    localparam logic [2:0] STR_SEQ     = 3'd5;
    localparam logic [2:0] STR_EVENT   = 3'd7;

    localparam logic [1:0] HDR_LAST = 2'd3;
    localparam logic [3:0] ANN_LEN  = 4'd13;

    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;

    typedef struct packed {
        logic [7:0] echo_byte;
        logic [3:0] field_code;
        logic       is_terminator;
        logic       end_of_frame;
        t_err       error_code;
        t_seq       sequence_number;
        logic       to_empty;
        logic       is_announce;
    } t_result;

    function automatic logic [7:0] magic_byte(input logic [1:0] idx);
        logic [7:0] c;
        unique case (idx)
            2'd0:    c = 8'hAA;
            2'd1:    c = 8'hAA;
            2'd2:    c = 8'h30;
            default: c = 8'h33;
        endcase
        return c;
    endfunction

    // Announce subject text, one character per index.
    function automatic logic [7:0] announce_char(input logic [3:0] idx);
        logic [7:0] c;
        unique case (idx)
            4'd0:    c = 8'h24;  // $
            4'd1:    c = 8'h45;  // E
            4'd2:    c = 8'h50;  // P
            4'd3:    c = 8'h3A;  // :
            4'd4:    c = 8'h3A;  // :
            4'd5:    c = 8'h41;  // A
            4'd6:    c = 8'h4E;  // N
            4'd7:    c = 8'h4E;  // N
            4'd8:    c = 8'h4F;  // O
            4'd9:    c = 8'h55;  // U
            4'd10:   c = 8'h4E;  // N
            4'd11:   c = 8'h43;  // C
            4'd12:   c = 8'h45;  // E
            default: c = 8'h00;
        endcase
        return c;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/core/mfd_if.sv =====
// Valid/ready channel interfaces for the deframer's byte input and result output.
`default_nettype none

interface mfd_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       restart;

    modport source (output valid, output data_byte, output restart, input ready);
    modport sink   (input valid, input data_byte, input restart, output ready);
endinterface

interface mfd_result_if;
    logic              valid;
    logic              ready;
    logic [7:0]        echo_byte;
    logic [3:0]        field_code;
    logic              is_terminator;
    logic              end_of_frame;
    logic [2:0]        error_code;
    logic signed [31:0] sequence_number;
    logic              to_empty;
    logic              is_announce;

    modport source (
        output valid, output echo_byte, output field_code, output is_terminator,
        output end_of_frame, output error_code, output sequence_number,
        output to_empty, output is_announce, input ready
    );
    modport sink (
        input valid, input echo_byte, input field_code, input is_terminator,
        input end_of_frame, input error_code, input sequence_number,
        input to_empty, input is_announce, output ready
    );
endinterface

`default_nettype wire

// ===== rtl/core/mfd_parser.sv =====
// Frame parser: per-byte state update and result labeling in a single pass.
`default_nettype none

module mfd_parser #(
    parameter int LENGTH_BITS = 32,
    parameter int SEQ_BITS    = 32
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_take,
    input  wire logic [7:0]       i_data_byte,
    input  wire logic             i_restart,
    output mfd_pkg::t_result      o_result
);

    mfd_pkg::t_phase      r_phase, n_phase, c_phase;
    logic [1:0]           r_hbc, n_hbc, c_hbc;
    logic [2:0]           r_str_idx, n_str_idx, c_str_idx;
    logic [LENGTH_BITS-1:0] r_rem, n_rem, c_rem;
    logic [SEQ_BITS-1:0]  r_acc, n_acc, c_acc;
    logic                 r_neg, n_neg, c_neg;
    logic                 r_done, n_done, c_done;
    logic                 r_started, n_started, c_started;
    logic [3:0]           r_smi, n_smi, c_smi;
    logic                 r_sm, n_sm, c_sm;
    logic                 r_dest_empty, n_dest_empty, c_dest_empty;
    mfd_pkg::t_err        r_err, n_err, c_err;

    logic [LENGTH_BITS-1:0] rem_dec;
    logic [SEQ_BITS-1:0]    acc_digit;
    logic [SEQ_BITS-1:0]    seq_mag;
    logic                   is_space;
    logic                   is_digit;
    mfd_pkg::t_err          err;
    logic                   term;
    logic                   eof;
    logic                   subj_done;
    logic [3:0]             field;

    // A restart beat sees the reset state.
    always_comb begin
        if (i_restart) begin
            c_phase      = mfd_pkg::PH_MAGIC;
            c_hbc        = '0;
            c_str_idx    = '0;
            c_rem        = '0;
            c_acc        = '0;
            c_neg        = 1'b0;
            c_done       = 1'b0;
            c_started    = 1'b0;
            c_smi        = '0;
            c_sm         = 1'b1;
            c_dest_empty = 1'b1;
            c_err        = mfd_pkg::ERR_NONE;
        end else begin
            c_phase      = r_phase;
            c_hbc        = r_hbc;
            c_str_idx    = r_str_idx;
            c_rem        = r_rem;
            c_acc        = r_acc;
            c_neg        = r_neg;
            c_done       = r_done;
            c_started    = r_started;
            c_smi        = r_smi;
            c_sm         = r_sm;
            c_dest_empty = r_dest_empty;
            c_err        = r_err;
        end
    end

    assign rem_dec   = c_rem - LENGTH_BITS'(1);
    assign acc_digit = (c_acc << 3) + (c_acc << 1) + SEQ_BITS'(i_data_byte[3:0]);
    assign is_space  = (i_data_byte == mfd_pkg::CH_SPACE) ||
                       ((i_data_byte >= mfd_pkg::CH_TAB) && (i_data_byte <= mfd_pkg::CH_CR));
    assign is_digit  = (i_data_byte >= mfd_pkg::CH_ZERO) && (i_data_byte <= mfd_pkg::CH_NINE);

    always_comb begin
        n_phase      = c_phase;
        n_hbc        = c_hbc;
        n_str_idx    = c_str_idx;
        n_rem        = c_rem;
        n_acc        = c_acc;
        n_neg        = c_neg;
        n_done       = c_done;
        n_started    = c_started;
        n_smi        = c_smi;
        n_sm         = c_sm;
        n_dest_empty = c_dest_empty;
        n_err        = c_err;
        err          = mfd_pkg::ERR_NONE;
        term         = 1'b0;
        eof          = 1'b0;

        // Once an error is held, nothing moves until restart.
        if (c_err == mfd_pkg::ERR_NONE) begin
            unique case (c_phase)
                mfd_pkg::PH_MAGIC: begin
                    if (c_hbc == '0) begin
                        n_acc        = '0;
                        n_neg        = 1'b0;
                        n_done       = 1'b0;
                        n_started    = 1'b0;
                        n_smi        = '0;
                        n_sm         = 1'b1;
                        n_dest_empty = 1'b1;
                    end
                    if (i_data_byte != mfd_pkg::magic_byte(c_hbc)) begin
                        err = mfd_pkg::ERR_MAGIC;
                    end else if (c_hbc == mfd_pkg::HDR_LAST) begin
                        n_phase = mfd_pkg::PH_LENGTH;
                        n_hbc   = '0;
                        n_rem   = '0;
                    end else begin
                        n_hbc = c_hbc + 2'd1;
                    end
                end
                mfd_pkg::PH_LENGTH: begin
                    // Only the low bits of a wide length survive the shift.
                    n_rem = {c_rem[LENGTH_BITS-9:0], i_data_byte};
                    if (c_hbc == mfd_pkg::HDR_LAST) begin
                        n_hbc = '0;
                        if (n_rem < LENGTH_BITS'(4)) begin
                            err = mfd_pkg::ERR_SHORT;
                        end else begin
                            n_phase = mfd_pkg::PH_PROTO;
                        end
                    end else begin
                        n_hbc = c_hbc + 2'd1;
                    end
                end
                mfd_pkg::PH_PROTO: begin
                    n_rem = rem_dec;
                    if (i_data_byte != mfd_pkg::CH_NUL) begin
                        err = mfd_pkg::ERR_PROTOCOL;
                    end else if (c_hbc == mfd_pkg::HDR_LAST) begin
                        n_hbc = '0;
                        if (rem_dec == '0) begin
                            err = mfd_pkg::ERR_OVERRUN;
                        end else begin
                            n_phase   = mfd_pkg::PH_STRING;
                            n_str_idx = '0;
                        end
                    end else begin
                        n_hbc = c_hbc + 2'd1;
                    end
                end
                mfd_pkg::PH_STRING: begin
                    n_rem = rem_dec;
                    if (i_data_byte == mfd_pkg::CH_NUL) begin
                        term = 1'b1;
                        if (c_str_idx == mfd_pkg::STR_SUBJECT && c_smi != mfd_pkg::ANN_LEN) begin
                            n_sm = 1'b0;
                        end
                        if (rem_dec == '0) begin
                            if (c_str_idx == mfd_pkg::STR_EVENT) begin
                                eof     = 1'b1;
                                n_phase = mfd_pkg::PH_MAGIC;
                            end else begin
                                err = mfd_pkg::ERR_MISSING;
                            end
                        end else if (c_str_idx == mfd_pkg::STR_EVENT) begin
                            n_phase = mfd_pkg::PH_CONTENT;
                        end else begin
                            n_str_idx = c_str_idx + 3'd1;
                        end
                    end else begin
                        if (c_str_idx == mfd_pkg::STR_DEST) begin
                            n_dest_empty = 1'b0;
                        end else if (c_str_idx == mfd_pkg::STR_SUBJECT) begin
                            if (c_smi < mfd_pkg::ANN_LEN &&
                                i_data_byte == mfd_pkg::announce_char(c_smi)) begin
                                n_smi = c_smi + 4'd1;
                            end else begin
                                n_sm = 1'b0;
                            end
                        end else if (c_str_idx == mfd_pkg::STR_SEQ && !c_done) begin
                            // Skip leading blanks, take one sign, then digits.
                            if (!c_started && is_space) begin
                                n_started = 1'b0;
                            end else if (!c_started && (i_data_byte == mfd_pkg::CH_PLUS ||
                                                        i_data_byte == mfd_pkg::CH_MINUS)) begin
                                n_started = 1'b1;
                                n_neg     = (i_data_byte == mfd_pkg::CH_MINUS);
                            end else if (is_digit) begin
                                n_started = 1'b1;
                                n_acc     = acc_digit;
                            end else begin
                                n_done = 1'b1;
                            end
                        end
                        if (rem_dec == '0) begin
                            err = mfd_pkg::ERR_OVERRUN;
                        end
                    end
                end
                mfd_pkg::PH_CONTENT: begin
                    n_rem = rem_dec;
                    if (rem_dec == '0) begin
                        eof     = 1'b1;
                        n_phase = mfd_pkg::PH_MAGIC;
                    end
                end
                default: begin
                    n_phase = mfd_pkg::PH_MAGIC;
                    n_hbc   = '0;
                end
            endcase
            n_err = err;
        end
    end

    always_comb begin
        unique case (c_phase)
            mfd_pkg::PH_MAGIC:   field = mfd_pkg::FIELD_MAGIC;
            mfd_pkg::PH_LENGTH:  field = mfd_pkg::FIELD_LENGTH;
            mfd_pkg::PH_PROTO:   field = mfd_pkg::FIELD_PROTO;
            mfd_pkg::PH_STRING:  field = mfd_pkg::FIELD_STR0 + 4'(c_str_idx);
            mfd_pkg::PH_CONTENT: field = mfd_pkg::FIELD_CONTENT;
            default:             field = mfd_pkg::FIELD_MAGIC;
        endcase
    end

    // The subject is settled once the parser is past it or the frame closed.
    assign subj_done = eof || (n_phase == mfd_pkg::PH_CONTENT) ||
                       ((n_phase == mfd_pkg::PH_STRING) && (n_str_idx > mfd_pkg::STR_SUBJECT));

    assign seq_mag = n_neg ? (SEQ_BITS'(0) - n_acc) : n_acc;

    always_comb begin
        o_result.echo_byte       = i_data_byte;
        o_result.field_code      = field;
        o_result.is_terminator   = term;
        o_result.end_of_frame    = eof;
        o_result.error_code      = n_err;
        o_result.sequence_number = mfd_pkg::t_seq'($signed(seq_mag));
        o_result.to_empty        = n_dest_empty;
        o_result.is_announce     = n_dest_empty && n_sm && subj_done;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= mfd_pkg::PH_MAGIC;
            r_hbc        <= '0;
            r_str_idx    <= '0;
            r_rem        <= '0;
            r_acc        <= '0;
            r_neg        <= 1'b0;
            r_done       <= 1'b0;
            r_started    <= 1'b0;
            r_smi        <= '0;
            r_sm         <= 1'b1;
            r_dest_empty <= 1'b1;
            r_err        <= mfd_pkg::ERR_NONE;
        end else if (i_take) begin
            r_phase      <= n_phase;
            r_hbc        <= n_hbc;
            r_str_idx    <= n_str_idx;
            r_rem        <= n_rem;
            r_acc        <= n_acc;
            r_neg        <= n_neg;
            r_done       <= n_done;
            r_started    <= n_started;
            r_smi        <= n_smi;
            r_sm         <= n_sm;
            r_dest_empty <= n_dest_empty;
            r_err        <= n_err;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/mfd_out_buf.sv =====
// Result register with a skid stage so input stays open while a result waits.
`default_nettype none

module mfd_out_buf (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_valid,
    output      logic              o_ready,
    input  wire mfd_pkg::t_result  i_data,
    output      logic              o_valid,
    input  wire logic              i_ready,
    output      mfd_pkg::t_result  o_data
);

    logic             r_out_valid;
    logic             r_skid_valid;
    mfd_pkg::t_result r_out;
    mfd_pkg::t_result r_skid;
    logic             take_in;
    logic             take_out;

    assign o_ready  = !r_skid_valid;
    assign o_valid  = r_out_valid;
    assign o_data   = r_out;
    assign take_in  = i_valid && !r_skid_valid;
    assign take_out = r_out_valid && i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (r_skid_valid) begin
            if (take_out) begin
                r_skid_valid <= 1'b0;
            end
        end else if (take_in) begin
            if (!r_out_valid || take_out) begin
                r_out_valid <= 1'b1;
            end else begin
                r_skid_valid <= 1'b1;
            end
        end else if (take_out) begin
            r_out_valid <= 1'b0;
        end
    end

    // Payload moves without reset; the valid flags above qualify it.
    always_ff @(posedge i_clk) begin
        if (r_skid_valid) begin
            if (take_out) begin
                r_out <= r_skid;
            end
        end else if (take_in) begin
            if (!r_out_valid || take_out) begin
                r_out <= i_data;
            end else begin
                r_skid <= i_data;
            end
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/message_frame_deframer.sv =====
// Byte-serial message frame deframer, top level.
// Takes one stream byte per beat and returns one labeled result beat for it:
// field code, string terminator and end-of-frame marks, the held error code,
// the running decimal sequence number, and the empty-destination and announce
// flags. The parser finishes each byte in the cycle it is accepted, so the block
// sustains one byte per clock while input ready is high; each result is registered.
// The result register is backed by a skid stage, so one more byte is taken
// while a result waits, and input ready drops only when both are full.
// A beat with restart set discards any partial frame and clears a held error
// before its byte is parsed. Errors otherwise persist until restart.
`default_nettype none

module message_frame_deframer #(
    parameter int LENGTH_BITS = 32,
    parameter int SEQ_BITS    = 32
) (
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    mfd_byte_if.sink      i_byte,
    mfd_result_if.source  o_result
);

    mfd_pkg::t_result parsed;
    mfd_pkg::t_result buffered;
    logic             in_ready;
    logic             take;

    assign i_byte.ready = in_ready;
    assign take         = i_byte.valid && in_ready;

    mfd_parser #(
        .LENGTH_BITS (LENGTH_BITS),
        .SEQ_BITS    (SEQ_BITS)
    ) u_parser (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_take      (take),
        .i_data_byte (i_byte.data_byte),
        .i_restart   (i_byte.restart),
        .o_result    (parsed)
    );

    mfd_out_buf u_out_buf (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_byte.valid),
        .o_ready (in_ready),
        .i_data  (parsed),
        .o_valid (o_result.valid),
        .i_ready (o_result.ready),
        .o_data  (buffered)
    );

    assign o_result.echo_byte       = buffered.echo_byte;
    assign o_result.field_code      = buffered.field_code;
    assign o_result.is_terminator   = buffered.is_terminator;
    assign o_result.end_of_frame    = buffered.end_of_frame;
    assign o_result.error_code      = buffered.error_code;
    assign o_result.sequence_number = buffered.sequence_number;
    assign o_result.to_empty        = buffered.to_empty;
    assign o_result.is_announce     = buffered.is_announce;

endmodule

`default_nettype wire
